// ===== sv/tcl_pkg.sv =====
// Shared types, segment tables and widths for the thermocouple linearizer.
`timescale 1ns / 1ps
package tcl_pkg;

  localparam int TCL_QUEUE_DEPTH = 4;

  localparam int SAMPLE_W     = 16;
  localparam int TENTHS_W     = 14;
  localparam int OUT_TDATA_W  = 16;
  localparam int COMP_W       = 10;
  localparam int JQ_W         = 14;   // junction reading in 1/32 degree
  localparam int CJ_SEGS      = 9;
  localparam int TC_SEGS      = 21;
  localparam int TC_NEG_SEGS  = 2;
  localparam int CJ_IDX_W     = 4;
  localparam int TC_IDX_W     = 5;
  localparam int MUL_A_W      = 9;
  localparam int MUL_B_W      = 11;
  localparam int NUM_W        = 19;
  localparam int RECIP_SHIFT  = 30;
  localparam int RECIP_W      = 26;
  localparam int QUO_W        = 12;
  localparam int RECIP_ONE    = 1 << RECIP_SHIFT;
  localparam int TCL_COMP_MAX = 656;

  localparam logic [SAMPLE_W-1:0] TC_LOW_CODE = 16'hFF6C;
  localparam logic [SAMPLE_W-1:0] TC_TOP_CODE = 16'h0A52;

  typedef enum logic {
    MODE_JUNCTION = 1'b0,
    MODE_COUPLE   = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t                 mode;
    logic [SAMPLE_W-1:0]   sample;
    logic                  jhit;
    logic [CJ_IDX_W-1:0]   jseg;
  } item_t;

  // Cold-junction table: segment i covers (hi[i-1], hi[i]].
  localparam logic [JQ_W-1:0] CJ_HI [CJ_SEGS] = '{
    14'd160, 14'd320, 14'd640, 14'd960, 14'd1280, 14'd1600, 14'd1920, 14'd2560, 14'd4000
  };
  localparam logic [JQ_W-1:0] CJ_BASE [CJ_SEGS] = '{
    14'd0, 14'd160, 14'd320, 14'd640, 14'd960, 14'd1280, 14'd1600, 14'd1920, 14'd2560
  };
  localparam logic [COMP_W-1:0] CJ_Y0 [CJ_SEGS] = '{
    10'd0, 10'd25, 10'd51, 10'd102, 10'd154, 10'd206, 10'd259, 10'd312, 10'd418
  };
  localparam logic [MUL_A_W-1:0] CJ_DY [CJ_SEGS] = '{
    9'd25, 9'd26, 9'd51, 9'd52, 9'd52, 9'd53, 9'd53, 9'd106, 9'd238
  };
  localparam logic [RECIP_W-1:0] CJ_RECIP [CJ_SEGS] = '{
    RECIP_W'((RECIP_ONE + 159) / 160),  RECIP_W'((RECIP_ONE + 159) / 160),
    RECIP_W'((RECIP_ONE + 319) / 320),  RECIP_W'((RECIP_ONE + 319) / 320),
    RECIP_W'((RECIP_ONE + 319) / 320),  RECIP_W'((RECIP_ONE + 319) / 320),
    RECIP_W'((RECIP_ONE + 319) / 320),  RECIP_W'((RECIP_ONE + 639) / 640),
    RECIP_W'((RECIP_ONE + 1439) / 1440)
  };

  // Thermocouple table: two segments below zero, then contiguous up to 0x0A52.
  localparam logic [SAMPLE_W-1:0] TC_HI [TC_SEGS] = '{
    16'hFFB5, 16'hFFFF, 16'h0019, 16'h0033, 16'h0066, 16'h009A, 16'h00CE,
    16'h0103, 16'h0138, 16'h01A2, 16'h020C, 16'h02DE, 16'h03AC, 16'h0478,
    16'h0548, 16'h061B, 16'h06F2, 16'h07C7, 16'h089F, 16'h0978, 16'h0A52
  };
  localparam logic [SAMPLE_W-1:0] TC_BASE [TC_SEGS] = '{
    16'hFF6C, 16'hFFB5, 16'h0000, 16'h0019, 16'h0033, 16'h0066, 16'h009A,
    16'h00CE, 16'h0103, 16'h0138, 16'h01A2, 16'h020C, 16'h02DE, 16'h03AB,
    16'h0478, 16'h0548, 16'h061B, 16'h06F2, 16'h07C7, 16'h089F, 16'h0978
  };
  // Start value in tenths; below-zero segments use TC_NEGC instead.
  localparam logic [TENTHS_W-1:0] TC_OFF [TC_SEGS] = '{
    14'd0, 14'd0, 14'd0, 14'd50, 14'd100, 14'd200, 14'd300, 14'd400, 14'd500,
    14'd600, 14'd800, 14'd1000, 14'd1400, 14'd1800, 14'd2200, 14'd2600,
    14'd3000, 14'd3400, 14'd3800, 14'd4200, 14'd4600
  };
  localparam logic [MUL_A_W-1:0] TC_DY10 [TC_SEGS] = '{
    9'd150, 9'd150, 9'd50, 9'd50, 9'd100, 9'd100, 9'd100, 9'd100, 9'd100,
    9'd200, 9'd200, 9'd400, 9'd400, 9'd400, 9'd400, 9'd400, 9'd400, 9'd400,
    9'd400, 9'd400, 9'd400
  };
  // Magnitude numerator base for below-zero segments: 10 * |start| * span.
  localparam logic [NUM_W-1:0] TC_NEGC [TC_SEGS] = '{
    19'd21900, 19'd11250, 19'd0, 19'd0, 19'd0, 19'd0, 19'd0, 19'd0, 19'd0,
    19'd0, 19'd0, 19'd0, 19'd0, 19'd0, 19'd0, 19'd0, 19'd0, 19'd0, 19'd0,
    19'd0, 19'd0
  };
  localparam logic [RECIP_W-1:0] TC_RECIP [TC_SEGS] = '{
    RECIP_W'((RECIP_ONE + 72) / 73),   RECIP_W'((RECIP_ONE + 74) / 75),
    RECIP_W'((RECIP_ONE + 24) / 25),   RECIP_W'((RECIP_ONE + 25) / 26),
    RECIP_W'((RECIP_ONE + 50) / 51),   RECIP_W'((RECIP_ONE + 51) / 52),
    RECIP_W'((RECIP_ONE + 51) / 52),   RECIP_W'((RECIP_ONE + 52) / 53),
    RECIP_W'((RECIP_ONE + 52) / 53),   RECIP_W'((RECIP_ONE + 105) / 106),
    RECIP_W'((RECIP_ONE + 105) / 106), RECIP_W'((RECIP_ONE + 209) / 210),
    RECIP_W'((RECIP_ONE + 205) / 206), RECIP_W'((RECIP_ONE + 204) / 205),
    RECIP_W'((RECIP_ONE + 207) / 208), RECIP_W'((RECIP_ONE + 210) / 211),
    RECIP_W'((RECIP_ONE + 214) / 215), RECIP_W'((RECIP_ONE + 212) / 213),
    RECIP_W'((RECIP_ONE + 215) / 216), RECIP_W'((RECIP_ONE + 216) / 217),
    RECIP_W'((RECIP_ONE + 217) / 218)
  };

endpackage

// ===== sv/tcl_front.sv =====
// Input register stage: takes beats and classifies junction readings by segment.
`timescale 1ns / 1ps
module tcl_front
  import tcl_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_mode,
  input  logic [SAMPLE_W-1:0] in_sample,
  output logic                q_valid,
  input  logic                q_ready,
  output item_t               q_item
);

  logic  f_valid_r;
  item_t f_item_r;
  item_t f_item_nxt;
  logic  [JQ_W-1:0] jq;
  logic  q_push;

  assign q_push   = f_valid_r && q_ready;
  assign in_ready = !f_valid_r || q_push;
  assign q_valid  = f_valid_r;
  assign q_item   = f_item_r;

  // Find the compensation segment; readings above the top bound get no hit.
  always_comb begin
    jq = in_sample[SAMPLE_W-1:SAMPLE_W-JQ_W];
    f_item_nxt.mode   = mode_t'(in_mode);
    f_item_nxt.sample = in_sample;
    f_item_nxt.jhit   = 1'b0;
    f_item_nxt.jseg   = '0;
    for (int i = CJ_SEGS - 1; i >= 0; i--) begin
      if (jq <= CJ_HI[i]) begin
        f_item_nxt.jhit = 1'b1;
        f_item_nxt.jseg = CJ_IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (in_ready) begin
      f_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      f_item_r <= f_item_nxt;
    end
  end

endmodule

// ===== sv/tcl_queue.sv =====
// Small register FIFO between the front stage and the arithmetic pipeline.
`timescale 1ns / 1ps
module tcl_queue
  import tcl_pkg::*;
#(
  parameter int DEPTH = TCL_QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  item_t         mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push, pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count above depth");
`endif

endmodule

// ===== sv/tcl_back.sv =====
// Arithmetic pipeline: segment select, multiply, reciprocal divide, result register.
`timescale 1ns / 1ps
module tcl_back
  import tcl_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_ready,
  input  item_t               q_item,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [TENTHS_W-1:0] out_tenths,
  output logic                out_oor
);

  localparam int PROD_W = MUL_A_W + MUL_B_W;
  localparam int FULL_W = NUM_W + RECIP_W;

  logic                en;
  logic                hazard;
  logic                take;

  // Stage 1
  logic [SAMPLE_W-1:0] code;
  logic [JQ_W-1:0]     jq;
  logic                thit;
  logic [TC_IDX_W-1:0] tseg;
  logic                s1_hit;
  logic [TC_IDX_W-1:0] s1_idx;
  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [PROD_W-1:0]   prod;

  logic                p1_valid_r;
  mode_t               p1_mode_r;
  logic                p1_hit_r;
  logic [TC_IDX_W-1:0] p1_idx_r;
  logic [NUM_W-1:0]    p1_num_r, p1_num_nxt;

  // Stage 2
  logic                p1_neg;
  logic [NUM_W-1:0]    num;
  logic [RECIP_W-1:0]  recip;
  logic [FULL_W-1:0]   full;

  logic                p2_valid_r;
  mode_t               p2_mode_r;
  logic                p2_hit_r;
  logic [TC_IDX_W-1:0] p2_idx_r;
  logic [QUO_W-1:0]    p2_quo_r, p2_quo_nxt;

  // Stage 3
  logic                p2_neg;
  logic [COMP_W-1:0]   comp_r, comp_nxt;
  logic [TENTHS_W-1:0] tenths_nxt;

  logic                out_valid_r;
  logic [TENTHS_W-1:0] out_tenths_r;
  logic                out_oor_r;

  assign en = !out_valid_r || out_ready;

  // Hold a thermocouple beat until no junction beat ahead can still rewrite the compensation.
  assign hazard = (q_item.mode == MODE_COUPLE) &&
                  ((p1_valid_r && p1_mode_r == MODE_JUNCTION) ||
                   (p2_valid_r && p2_mode_r == MODE_JUNCTION));
  assign take    = en && q_valid && !hazard;
  assign q_ready = en && !hazard;

  always_comb begin
    code = q_item.sample + SAMPLE_W'(comp_r);
    jq   = q_item.sample[SAMPLE_W-1:SAMPLE_W-JQ_W];
    thit = 1'b0;
    tseg = '0;
    if (code > TC_LOW_CODE) begin
      thit = 1'b1;
      tseg = (code <= TC_HI[0]) ? TC_IDX_W'(0) : TC_IDX_W'(1);
    end else if (code <= TC_TOP_CODE) begin
      thit = 1'b1;
      for (int i = TC_SEGS - 1; i >= TC_NEG_SEGS; i--) begin
        if (code <= TC_HI[i]) begin
          tseg = TC_IDX_W'(i);
        end
      end
    end

    if (q_item.mode == MODE_JUNCTION) begin
      s1_hit = q_item.jhit;
      s1_idx = TC_IDX_W'(q_item.jseg);
      mul_a  = CJ_DY[q_item.jseg];
      mul_b  = q_item.jhit ? MUL_B_W'(jq - CJ_BASE[q_item.jseg]) : '0;
    end else begin
      s1_hit = thit;
      s1_idx = tseg;
      mul_a  = TC_DY10[tseg];
      mul_b  = thit ? MUL_B_W'(code - TC_BASE[tseg]) : '0;
    end
    prod       = PROD_W'(mul_a) * PROD_W'(mul_b);
    p1_num_nxt = prod[NUM_W-1:0];
  end

  // Divide by the segment span through its reciprocal; below zero divide the magnitude.
  always_comb begin
    p1_neg = (p1_mode_r == MODE_COUPLE) && (p1_idx_r < TC_IDX_W'(TC_NEG_SEGS));
    num    = p1_neg ? TC_NEGC[p1_idx_r] - p1_num_r : p1_num_r;
    recip  = (p1_mode_r == MODE_COUPLE) ? TC_RECIP[p1_idx_r]
                                        : CJ_RECIP[p1_idx_r[CJ_IDX_W-1:0]];
    full   = FULL_W'(num) * FULL_W'(recip);
    p2_quo_nxt = full[RECIP_SHIFT +: QUO_W];
  end

  always_comb begin
    p2_neg   = p2_idx_r < TC_IDX_W'(TC_NEG_SEGS);
    comp_nxt = p2_hit_r ? CJ_Y0[p2_idx_r[CJ_IDX_W-1:0]] + COMP_W'(p2_quo_r) : '0;
    if (!p2_hit_r) begin
      tenths_nxt = '0;
    end else if (p2_neg) begin
      tenths_nxt = '0 - TENTHS_W'(p2_quo_r);
    end else begin
      tenths_nxt = TC_OFF[p2_idx_r] + TENTHS_W'(p2_quo_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r  <= 1'b0;
      p2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      comp_r      <= '0;
    end else if (en) begin
      p1_valid_r  <= take;
      p2_valid_r  <= p1_valid_r;
      out_valid_r <= p2_valid_r && (p2_mode_r == MODE_COUPLE);
      if (p2_valid_r && p2_mode_r == MODE_JUNCTION) begin
        comp_r <= comp_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_mode_r    <= q_item.mode;
      p1_hit_r     <= s1_hit;
      p1_idx_r     <= s1_idx;
      p1_num_r     <= p1_num_nxt;
      p2_mode_r    <= p1_mode_r;
      p2_hit_r     <= p1_hit_r;
      p2_idx_r     <= p1_idx_r;
      p2_quo_r     <= p2_quo_nxt;
      out_tenths_r <= tenths_nxt;
      out_oor_r    <= !p2_hit_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_tenths = out_tenths_r;
  assign out_oor    = out_oor_r;

`ifndef NO_ASSERTIONS
  a_no_stale_comp: assert property (@(posedge clk) disable iff (!rst_n)
    (p1_valid_r && p1_mode_r == MODE_COUPLE) |-> !(p2_valid_r && p2_mode_r == MODE_JUNCTION))
    else $error("thermocouple beat overtook a compensation update");
  a_comp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    comp_r <= COMP_W'(TCL_COMP_MAX))
    else $error("compensation code above table maximum");
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_oor_r) |-> (out_tenths_r == '0))
    else $error("out-of-range beat with nonzero temperature");
`endif

endmodule

// ===== sv/thermocouple_cold_junction_linearizer.sv =====
// Top level: front stage, queue and arithmetic pipeline of the thermocouple linearizer.
// A thermocouple beat passes the front register, the queue and the p1, p2 and output registers.
// Throughput: one beat per cycle while out_tready does not stall; a thermocouple beat right
// behind a junction beat waits in the queue until that junction beat has written the compensation.
// Junction beats (in_tuser = 0) update the compensation and produce no output beat.
// Reset (rst_n low, synchronous) empties all stages and clears the compensation to 0.
`timescale 1ns / 1ps
module thermocouple_cold_junction_linearizer
  import tcl_pkg::*;
#(
  parameter int QUEUE_DEPTH = TCL_QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [SAMPLE_W-1:0]    in_tdata,   // [15:0] sample
  input  logic                   in_tuser,   // [0] mode
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [13:0] temperature_tenths, [15:14] zero
  output logic                   out_tuser   // [0] out_of_range
);

  logic                f_valid;
  logic                f_ready;
  item_t               f_item;
  logic                b_valid;
  logic                b_ready;
  item_t               b_item;
  logic [TENTHS_W-1:0] tenths;

  tcl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_mode   (in_tuser),
    .in_sample (in_tdata),
    .q_valid   (f_valid),
    .q_ready   (f_ready),
    .q_item    (f_item)
  );

  tcl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_item   (b_item)
  );

  tcl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (b_valid),
    .q_ready    (b_ready),
    .q_item     (b_item),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_tenths (tenths),
    .out_oor    (out_tuser)
  );

  assign out_tdata = {{(OUT_TDATA_W - TENTHS_W){1'b0}}, tenths};

endmodule
